FILE: hw/rtl/swpec_pkg.sv
// ----------------------------------------------------------------------------
// swpec_pkg
// Shared constants for the sliding window peak event counter.
// ----------------------------------------------------------------------------
package swpec_pkg;

   localparam int FIFO_DEPTH  = 1024;
   localparam int PTR_W       = $clog2(FIFO_DEPTH);
   localparam int OCC_W       = $clog2(FIFO_DEPTH + 1);
   localparam int STAMP_W     = 32;
   localparam int COUNT_W     = 32;
   localparam int WINDOW_W    = 32;
   localparam int RSP_FIELD_W = 3 * COUNT_W + 1;
   localparam int RSP_DATA_W  = ((RSP_FIELD_W + 7) / 8) * 8;

   localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(60);

endpackage

FILE: hw/rtl/swpec_ram.sv
// ----------------------------------------------------------------------------
// swpec_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module swpec_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/sliding_window_peak_event_count.sv
// ----------------------------------------------------------------------------
// sliding_window_peak_event_count
// Counts events in a sliding time window and tracks the peak window count.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+-------------------------------------
//  req     | in  | req_tvalid/req_tready | tdata: event_time
//  rsp     | out | rsp_tvalid/rsp_tready | tdata: count_in_window, peak_count,
//          |     |                       |        peak_time, overflow
//  csr     | in  | csr_valid/csr_ready   | csr_data: window_seconds
//
//  Flow: a repeated stamp or an empty FIFO goes from IDLE straight to FINISH;
//  a new stamp goes via SCAN, via EVICT first when the FIFO is full. The one
//  read port on the head entry limits SCAN to one head entry checked per cycle.
//  Reset: synchronous, active high; clears pointers, totals and peak. The
//  stamp and count memories are not cleared; only occupied entries are read.
//  Stalls: a finished result waits in the output register; the block holds
//  in its final state until that register is free.
//
module sliding_window_peak_event_count
   import swpec_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request: [31:0] event_time
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [STAMP_W-1:0]    req_tdata,
   // result: [31:0] count_in_window, [63:32] peak_count, [95:64] peak_time,
   //         [96] overflow, [103:97] zero
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // window_seconds write
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [WINDOW_W-1:0]   csr_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVICT,
      ST_SCAN,
      ST_FINISH
   } state_type;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [OCC_W-1:0]   OCC_FULL  = OCC_W'(FIFO_DEPTH);

   // advance a ring pointer with wrap at the FIFO depth
   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [COUNT_W-1:0] sat_sub(input logic [COUNT_W-1:0] a,
                                                   input logic [COUNT_W-1:0] b);
      return (a >= b) ? a - b : '0;
   endfunction

   // true when (window - 1) < signed(now - stamp)
   function automatic logic outside_window(input logic [WINDOW_W-1:0] win,
                                           input logic [STAMP_W-1:0]  now,
                                           input logic [STAMP_W-1:0]  stamp);
      logic [STAMP_W-1:0] diff;
      logic signed [STAMP_W:0] lhs;
      logic signed [STAMP_W:0] rhs;
      diff = now - stamp;
      lhs  = $signed({1'b0, win}) - 33'sd1;
      rhs  = $signed({diff[STAMP_W-1], diff});
      return lhs < rhs;
   endfunction

   // ------------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------------
   state_type               state_ff,   state_in;
   logic [WINDOW_W-1:0]     window_ff,  window_in;
   logic [PTR_W-1:0]        head_ff,    head_in;
   logic [PTR_W-1:0]        tail_ff,    tail_in;
   logic [OCC_W-1:0]        occ_ff,     occ_in;
   logic [COUNT_W-1:0]      total_ff,   total_in;
   logic [COUNT_W-1:0]      peak_ff,    peak_in;
   logic [STAMP_W-1:0]      peak_t_ff,  peak_t_in;
   logic [STAMP_W-1:0]      event_ff,   event_in;
   logic                    ovf_ff,     ovf_in;
   logic [STAMP_W-1:0]      newest_ff,  newest_in;
   logic [COUNT_W-1:0]      ncount_ff,  ncount_in;
   logic                    rsp_vld_ff, rsp_vld_in;
   logic [RSP_DATA_W-1:0]   rsp_dat_ff, rsp_dat_in;

   // memory ports
   logic                    stamp_we;
   logic                    count_we;
   logic [PTR_W-1:0]        wr_addr;
   logic [STAMP_W-1:0]      stamp_wdata;
   logic [COUNT_W-1:0]      count_wdata;
   logic [STAMP_W-1:0]      head_stamp;
   logic [COUNT_W-1:0]      head_count;

   logic                    req_fire;
   logic                    rsp_free;
   logic [PTR_W-1:0]        back_ptr;
   logic [COUNT_W-1:0]      total_inc;
   logic                    head_out;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_free   = ~rsp_vld_ff | rsp_tready;
   assign back_ptr   = (tail_ff == '0) ? PTR_W'(FIFO_DEPTH - 1) : tail_ff - 1'b1;
   assign total_inc  = (total_ff == COUNT_MAX) ? total_ff : total_ff + 1'b1;
   assign head_out   = outside_window(window_ff, event_ff, head_stamp);

   // ------------------------------------------------------------------------
   // next state
   // ------------------------------------------------------------------------
   always_comb begin
      state_in    = state_ff;
      window_in   = window_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      occ_in      = occ_ff;
      total_in    = total_ff;
      peak_in     = peak_ff;
      peak_t_in   = peak_t_ff;
      event_in    = event_ff;
      ovf_in      = ovf_ff;
      newest_in   = newest_ff;
      ncount_in   = ncount_ff;
      rsp_vld_in  = rsp_vld_ff & ~rsp_tready;
      rsp_dat_in  = rsp_dat_ff;
      stamp_we    = 1'b0;
      count_we    = 1'b0;
      wr_addr     = tail_ff;
      stamp_wdata = event_ff;
      count_wdata = COUNT_W'(1);

      if (csr_valid) begin
         window_in = csr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               event_in    = req_tdata;
               ovf_in      = 1'b0;
               total_in    = total_inc;
               stamp_wdata = req_tdata;
               if (occ_ff == '0) begin
                  // empty: append and finish
                  stamp_we  = 1'b1;
                  count_we  = 1'b1;
                  tail_in   = next_ptr(tail_ff);
                  occ_in    = occ_ff + 1'b1;
                  newest_in = req_tdata;
                  ncount_in = COUNT_W'(1);
                  state_in  = ST_FINISH;
               end else if (req_tdata == newest_ff) begin
                  // repeat of the newest stamp: bump its count in place
                  ncount_in   = (ncount_ff == COUNT_MAX) ? ncount_ff : ncount_ff + 1'b1;
                  count_we    = 1'b1;
                  wr_addr     = back_ptr;
                  count_wdata = ncount_in;
                  state_in    = ST_FINISH;
               end else if (occ_ff == OCC_FULL) begin
                  // full: head entry is read now, forced out next cycle
                  state_in = ST_EVICT;
               end else begin
                  stamp_we  = 1'b1;
                  count_we  = 1'b1;
                  tail_in   = next_ptr(tail_ff);
                  occ_in    = occ_ff + 1'b1;
                  newest_in = req_tdata;
                  ncount_in = COUNT_W'(1);
                  state_in  = ST_SCAN;
               end
            end
         end
         ST_EVICT: begin
            // drop the oldest entry and append into the freed slot
            ovf_in    = ~head_out;
            total_in  = sat_sub(total_ff, head_count);
            head_in   = next_ptr(head_ff);
            stamp_we  = 1'b1;
            count_we  = 1'b1;
            tail_in   = next_ptr(tail_ff);
            newest_in = event_ff;
            ncount_in = COUNT_W'(1);
            state_in  = ST_SCAN;
         end
         ST_SCAN: begin
            // drop aged-out head entries, one per cycle
            if ((occ_ff != '0) && head_out) begin
               total_in = sat_sub(total_ff, head_count);
               head_in  = next_ptr(head_ff);
               occ_in   = occ_ff - 1'b1;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               if (peak_ff < total_ff) begin
                  peak_in   = total_ff;
                  peak_t_in = event_ff;
               end
               rsp_vld_in = 1'b1;
               rsp_dat_in = RSP_DATA_W'({ovf_ff, peak_t_in, peak_in, total_ff});
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // state and registered outputs
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         window_ff  <= WINDOW_RESET;
         head_ff    <= '0;
         tail_ff    <= '0;
         occ_ff     <= '0;
         total_ff   <= '0;
         peak_ff    <= '0;
         peak_t_ff  <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         window_ff  <= window_in;
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         occ_ff     <= occ_in;
         total_ff   <= total_in;
         peak_ff    <= peak_in;
         peak_t_ff  <= peak_t_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      event_ff   <= event_in;
      ovf_ff     <= ovf_in;
      newest_ff  <= newest_in;
      ncount_ff  <= ncount_in;
      rsp_dat_ff <= rsp_dat_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_dat_ff;

   // ------------------------------------------------------------------------
   // stamp and count memories; read the next head so data lines up with head_ff
   // ------------------------------------------------------------------------
   swpec_ram #(
      .WIDTH (STAMP_W),
      .DEPTH (FIFO_DEPTH)
   ) u_stamp_ram (
      .clock   (clock),
      .wr_en   (stamp_we),
      .wr_addr (wr_addr),
      .wr_data (stamp_wdata),
      .rd_addr (head_in),
      .rd_data (head_stamp)
   );

   swpec_ram #(
      .WIDTH (COUNT_W),
      .DEPTH (FIFO_DEPTH)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (count_we),
      .wr_addr (wr_addr),
      .wr_data (count_wdata),
      .rd_addr (head_in),
      .rd_data (head_count)
   );

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------
   a_occ_bound : assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_FULL)
      else $error("occupancy above FIFO depth");

   a_ptr_match : assert property (@(posedge clock) disable iff (reset)
      ((({1'b0, head_ff} + occ_ff) >= OCC_FULL) ?
         (tail_ff == PTR_W'(({1'b0, head_ff} + occ_ff) - OCC_FULL)) :
         (tail_ff == PTR_W'({1'b0, head_ff} + occ_ff))))
      else $error("tail pointer disagrees with head plus occupancy");

   a_peak_mono : assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> (peak_ff >= $past(peak_ff)))
      else $error("peak total decreased");

   a_rsp_peak : assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> (rsp_dat_ff[2*COUNT_W-1:COUNT_W] >= rsp_dat_ff[COUNT_W-1:0]))
      else $error("result peak below window count");

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sliding window peak event counter. A tracker
// class keeps its own copy of the stamp FIFO, the totals and the peak, works
// out the tally that each accepted event must produce, and matches the
// returned tallies in order. Directed events cover wrap-around, decreasing
// stamps and the signed window compare. Random phases follow, each with its
// own window length. A long consecutive-stamp run fills the FIFO to force
// evictions without overflow, then with overflow once the window is widened.
// ----------------------------------------------------------------------------
module tb;
   import swpec_pkg::*;

   // tally fields as they come back on rsp_tdata
   typedef struct {
      logic [COUNT_W-1:0] count;
      logic [COUNT_W-1:0] peak;
      logic [STAMP_W-1:0] peak_time;
      logic               overflow;
   } tally_t;

   // -------------------------------------------------------------------------
   // Window tracker: mirrors the block's state and checks every tally
   // -------------------------------------------------------------------------
   class event_window_tracker;
      logic [STAMP_W-1:0]  stamps[FIFO_DEPTH];
      logic [COUNT_W-1:0]  counts[FIFO_DEPTH];
      int unsigned         head;
      int unsigned         tail;
      int unsigned         fill;
      logic [WINDOW_W-1:0] window;
      logic [COUNT_W-1:0]  total;
      logic [COUNT_W-1:0]  peak;
      logic [STAMP_W-1:0]  peak_at;
      tally_t              pending_tallies[$];
      int                  events_logged;
      int                  tallies_matched;
      int                  overflow_hits;
      int                  mismatches;

      function new();
         head            = 0;
         tail            = 0;
         fill            = 0;
         window          = WINDOW_RESET;
         total           = '0;
         peak            = '0;
         peak_at         = '0;
         events_logged   = 0;
         tallies_matched = 0;
         overflow_hits   = 0;
         mismatches      = 0;
      endfunction

      // signed distance from the stamp, compared with window - 1 without wrap
      function bit aged_out(logic [STAMP_W-1:0] now, logic [STAMP_W-1:0] stamp);
         logic [STAMP_W-1:0] diff;
         diff = now - stamp;
         return (longint'(window) - 1) < longint'($signed(diff));
      endfunction

      function void drop_oldest();
         total = (total >= counts[head]) ? total - counts[head] : '0;
         head  = (head + 1 >= FIFO_DEPTH) ? 0 : head + 1;
         fill--;
      endfunction

      function void push_stamp(logic [STAMP_W-1:0] t);
         stamps[tail] = t;
         counts[tail] = 1;
         tail         = (tail + 1 >= FIFO_DEPTH) ? 0 : tail + 1;
         fill++;
      endfunction

      function void log_event(logic [STAMP_W-1:0] t);
         tally_t      exp;
         int unsigned back;
         exp.overflow = 1'b0;
         if (total != '1) total++;
         if (fill == 0) begin
            push_stamp(t);
         end else begin
            back = (tail == 0) ? FIFO_DEPTH - 1 : tail - 1;
            if (stamps[back] == t) begin
               // repeat of the newest stamp: bump it, evict nothing
               if (counts[back] != '1) counts[back]++;
            end else begin
               if (fill >= FIFO_DEPTH) begin
                  // forced eviction; overflow only if the entry was still live
                  if (!aged_out(t, stamps[head])) exp.overflow = 1'b1;
                  drop_oldest();
               end
               push_stamp(t);
               while (fill > 0 && aged_out(t, stamps[head])) drop_oldest();
            end
         end
         if (peak < total) begin
            peak    = total;
            peak_at = t;
         end
         exp.count     = total;
         exp.peak      = peak;
         exp.peak_time = peak_at;
         pending_tallies.push_back(exp);
         events_logged++;
      endfunction

      function void note_mismatch(string what, logic [31:0] want, logic [31:0] got);
         mismatches++;
         if (mismatches <= 10)
            $display("  mismatch at tally %0d: %s expected %h got %h",
                     tallies_matched, what, want, got);
      endfunction

      function void match_tally(logic [RSP_DATA_W-1:0] data);
         tally_t exp;
         tally_t got;
         got.count     = data[31:0];
         got.peak      = data[63:32];
         got.peak_time = data[95:64];
         got.overflow  = data[96];
         if (got.overflow === 1'b1) overflow_hits++;
         if (pending_tallies.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("  unexpected tally %h with nothing outstanding", data);
            return;
         end
         exp = pending_tallies.pop_front();
         if (got.count !== exp.count)
            note_mismatch("count_in_window", exp.count, got.count);
         if (got.peak !== exp.peak)
            note_mismatch("peak_count", exp.peak, got.peak);
         if (got.peak_time !== exp.peak_time)
            note_mismatch("peak_time", exp.peak_time, got.peak_time);
         if (got.overflow !== exp.overflow)
            note_mismatch("overflow", 32'(exp.overflow), 32'(got.overflow));
         tallies_matched++;
      endfunction

      function int outstanding();
         return pending_tallies.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // DUT hookup
   // -------------------------------------------------------------------------
   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [STAMP_W-1:0]    req_tdata;   // [31:0] event_time
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // [31:0] count, [63:32] peak, [95:64] peak_time,
                                       // [96] overflow, [103:97] zero
   logic                  csr_valid;
   logic                  csr_ready;
   logic [WINDOW_W-1:0]   csr_data;

   sliding_window_peak_event_count u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   event_window_tracker tracker;
   bit                  quiet;           // no gaps on either side in this phase
   bit                  hold_done;
   int                  windows_written;
   logic [STAMP_W-1:0]  stamp_cursor;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // mostly back-to-back, some short gaps, a rare long one
   function int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 999);
      if (r < 700) return 0;
      if (r < 992) return $urandom_range(1, 3);
      return $urandom_range(15, 60);
   endfunction

   // offer one event at the falling edge; hold until the handshake completes
   task automatic send_event(input logic [STAMP_W-1:0] t);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = t;
      do @(posedge clock); while (req_tready !== 1'b1);
      tracker.log_event(t);
      @(negedge clock);
   endtask

   // drain every outstanding tally, then let the block settle
   task automatic wait_idle();
      req_tvalid = 1'b0;
      while (tracker.outstanding() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_window(input logic [WINDOW_W-1:0] w);
      wait_idle();
      csr_valid = 1'b1;
      csr_data  = w;
      do @(posedge clock); while (csr_ready !== 1'b1);
      tracker.window = w;
      windows_written++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function logic [WINDOW_W-1:0] pick_window(int k);
      case (k % 8)
         0:       return 1;
         1:       return 2;
         2:       return 60;
         3:       return $urandom_range(3, 40);
         4:       return $urandom_range(100, 3000);
         5:       return $urandom | 32'h8000_0000;
         6:       return 32'hFFFF_FFFF;
         default: return $urandom | 32'h1;
      endcase
   endfunction

   // mostly nondecreasing streams that hover around the window edge;
   // the rest repeats, big jumps, steps back and full-range noise
   task automatic run_random_phase(input int n, input logic [WINDOW_W-1:0] w);
      int                 r;
      int unsigned        lim;
      logic [STAMP_W-1:0] t;
      write_window(w);
      quiet = ($urandom_range(0, 3) == 0);
      lim   = (w > 200) ? 200 : w;
      t     = stamp_cursor;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 25)      t = t;
         else if (r < 72) t = t + $urandom_range(1, lim + lim / 2 + 1);
         else if (r < 80) t = t + $urandom_range(1, 5000);
         else if (r < 87) t = t + $urandom;
         else if (r < 94) t = t - $urandom_range(1, 100);
         else             t = $urandom;
         send_event(t);
      end
      stamp_cursor = t;
   endtask

   // -------------------------------------------------------------------------
   // Result side: random backpressure plus one long hold-off
   // -------------------------------------------------------------------------
   initial begin
      int stall;
      rsp_tready = 1'b0;
      hold_done  = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         stall = pick_gap();
         if (!hold_done && tracker.tallies_matched >= 300) begin
            // stall long enough that the block backs up into its input
            stall     = 400;
            hold_done = 1'b1;
         end
         if (stall > 0) begin
            rsp_tready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready = 1'b1;
         @(posedge clock);
         if (rsp_tvalid === 1'b1) tracker.match_tally(rsp_tdata);
         @(negedge clock);
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin
      int                 distinct;
      logic [STAMP_W-1:0] t;
      tracker         = new();
      reset           = 1'b1;
      req_tvalid      = 1'b0;
      req_tdata       = '0;
      csr_valid       = 1'b0;
      csr_data        = '0;
      quiet           = 1'b0;
      windows_written = 0;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      // reset window: repeats, wrap past the top, steps back, signed edge
      send_event(32'h0000_0000);
      send_event(32'h0000_0000);
      send_event(32'hFFFF_FFFF);
      send_event(32'h0000_0005);
      send_event(32'h0000_0064);
      send_event(32'h0000_001E);
      send_event(32'h0000_0082);
      send_event(32'h0000_0082);
      send_event(32'h0000_0083);
      send_event(32'h8000_0083);
      send_event(32'h8000_00BF);

      // shortest window: only the newest stamp survives
      write_window(32'd1);
      send_event(32'd7);
      send_event(32'd7);
      send_event(32'd8);
      send_event(32'd9);
      send_event(32'd11);
      send_event(32'd11);

      // longest window: nothing ages out
      write_window(32'hFFFF_FFFF);
      send_event(32'h0000_0000);
      send_event(32'h7FFF_FFFF);
      send_event(32'hFFFF_FFFF);
      send_event(32'h5555_5555);
      send_event(32'hAAAA_AAAA);

      stamp_cursor = 32'h0000_1000;
      for (int k = 0; k < 8; k++) run_random_phase(90, pick_window(k + $urandom_range(0, 7)));

      // fill the FIFO with consecutive stamps that all sit in a 1024 window;
      // once full, each new stamp evicts one that has just aged out
      write_window(32'd1024);
      quiet    = 1'b0;
      t        = stamp_cursor + 32'd5000;
      distinct = 0;
      while (distinct < 1040) begin
         if (distinct == 0 || $urandom_range(0, 19) != 0) begin
            t = t + 1;
            distinct++;
         end
         send_event(t);
      end

      // widen the window with the FIFO full: every new stamp now overflows
      write_window(32'hFFFF_FFFF);
      for (int i = 0; i < 40; i++) begin
         if ($urandom_range(0, 4) != 0) t = t + $urandom_range(1, 1000);
         send_event(t);
      end

      wait_idle();
      repeat (20) @(posedge clock);
      $display("Sent %0d events over %0d window settings; %0d tallies checked.",
               tracker.events_logged, windows_written, tracker.tallies_matched);
      $display("Tallies with overflow: %0d; final peak %0d at stamp %h.",
               tracker.overflow_hits, tracker.peak, tracker.peak_at);
      if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("Mismatches: %0d, tallies never returned: %0d",
                  tracker.mismatches, tracker.outstanding());
         $display("FAILURE");
      end
      $finish;
   end

   // watchdog: well beyond the slowest legal run
   initial begin
      #10_000_000;
      $display("Timed out with %0d tallies outstanding", tracker.outstanding());
      $display("FAILURE");
      $finish;
   end

endmodule
